/* rtl/sorted_list_merger_top_defines.svh */
// Assertion macros shared by the sorted list merger RTL.
`ifndef SORTED_LIST_MERGER_TOP_DEFINES_SVH
`define SORTED_LIST_MERGER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define SLM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define SLM_ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLM_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SLM_ASSERT_ALW(lbl, clk, prop, msg)
`endif

`endif

/* rtl/slm_pkg.sv */
// Shared constants and codes of the sorted list merger.
`default_nettype none

package slm_pkg;

  // Default number of entries in each list.
  localparam int CAPACITY_DEF = 32;

  // Width of one list element.
  localparam int DATA_W = 32;

  // Width of the operation selector.
  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MERGE  = 2'd2
  } op_t;

endpackage

`default_nettype wire

/* rtl/slm_list_mem.sv */
// Single-port-write, single-port-read list memory with a registered read.
`default_nettype none

module slm_list_mem #(
  parameter int AW = 5,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/sorted_list_merger_top.sv */
// Load items are accepted back to back while idle.
// A merge of N elements registers the merge state when the merge word is accepted,
// then places one word per cycle in the output register while the output does not
// stall, set by the one read port per list memory. No input word is taken until
// the last merge word is registered; a merge of two empty lists emits nothing.
// Reset clears both list counts; list memories are not cleared.
`default_nettype none
`include "sorted_list_merger_top_defines.svh"

module sorted_list_merger_top #(
  parameter int CAPACITY = slm_pkg::CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [slm_pkg::DATA_W-1:0] in_tdata,   // [31:0] value
  input  wire logic [slm_pkg::OP_W-1:0]   in_tuser,   // [1:0] op
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [slm_pkg::DATA_W-1:0] out_tdata,  // [31:0] merged_value
  output logic                            out_tlast
);

  import slm_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = $clog2(2 * CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]     cnt_b_r, cnt_b_nxt;
  logic [CW-1:0]     ia_r, ia_nxt;
  logic [CW-1:0]     ib_r, ib_nxt;
  logic [TW-1:0]     rem_r, rem_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic              out_tlast_r, out_tlast_nxt;

  logic              acc_in;
  logic              step;
  logic              take_a;
  logic              wr_a;
  logic              wr_b;
  logic [TW-1:0]     total;
  logic [DATA_W-1:0] head_a;
  logic [DATA_W-1:0] head_b;

  assign in_tready  = (state_r == ST_IDLE);
  assign acc_in     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // The read address follows the next pointer, so the read data is the current head.
  slm_list_mem #(.AW(AW), .DW(DATA_W)) u_mem_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (ia_nxt[AW-1:0]),
    .rd_data (head_a)
  );

  slm_list_mem #(.AW(AW), .DW(DATA_W)) u_mem_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (ib_nxt[AW-1:0]),
    .rd_data (head_b)
  );

  // Load decode; a load into a full list is dropped.
  assign wr_a  = acc_in && (in_tuser == OP_LOAD_A) && (cnt_a_r < CW'(CAPACITY));
  assign wr_b  = acc_in && (in_tuser == OP_LOAD_B) && (cnt_b_r < CW'(CAPACITY));
  assign total = TW'(cnt_a_r) + TW'(cnt_b_r);

  // One merge step whenever the output register is free or being drained.
  assign step   = (state_r == ST_MERGE) && (!out_tvalid_r || out_tready);
  assign take_a = (ia_r < cnt_a_r) &&
                  ((ib_r >= cnt_b_r) || ($signed(head_a) <= $signed(head_b)));

  // Next-state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    rem_nxt        = rem_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (wr_a) begin
          cnt_a_nxt = cnt_a_r + CW'(1);
        end
        if (wr_b) begin
          cnt_b_nxt = cnt_b_r + CW'(1);
        end
        if (acc_in && (in_tuser == OP_MERGE) && (total != '0)) begin
          state_nxt = ST_MERGE;
          rem_nxt   = total;
        end
      end
      ST_MERGE: begin
        if (step) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = take_a ? head_a : head_b;
          out_tlast_nxt  = (rem_r == TW'(1));
          rem_nxt        = rem_r - TW'(1);
          if (take_a) begin
            ia_nxt = ia_r + CW'(1);
          end else begin
            ib_nxt = ib_r + CW'(1);
          end
          // The final word empties both lists.
          if (rem_r == TW'(1)) begin
            state_nxt = ST_IDLE;
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            ia_nxt    = '0;
            ib_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      rem_r        <= '0;
      out_tvalid_r <= 1'b0;
      out_tlast_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      rem_r        <= rem_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_tlast_r  <= out_tlast_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
  end

  // Read pointers never pass the fill counts.
  `SLM_ASSERT_RST(a_ptr_bound, clk, rst_n, (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r), "read pointer past list end")

  // Fill counts stay within capacity.
  `SLM_ASSERT_RST(a_cnt_bound, clk, rst_n, (cnt_a_r <= CW'(CAPACITY)) && (cnt_b_r <= CW'(CAPACITY)), "list count above capacity")

  // While merging, words left plus words taken equal both list lengths.
  `SLM_ASSERT_RST(a_rem_sum, clk, rst_n, (state_r == ST_MERGE) |-> ((TW + 1)'(rem_r) + (TW + 1)'(ia_r) + (TW + 1)'(ib_r) == (TW + 1)'(total)), "merge bookkeeping mismatch")

  // The last word of a merge returns to idle with both lists empty.
  `SLM_ASSERT_RST(a_last_done, clk, rst_n, (step && (rem_r == TW'(1))) |=> ((state_r == ST_IDLE) && (cnt_a_r == '0) && (cnt_b_r == '0) && out_tlast_r), "merge did not finish cleanly")

endmodule

`default_nettype wire
